// ===== rtl/art1_pkg.sv =====
// Package for the ART1 binary clustering block.
// Holds the transaction payload types, codes, register indexes and reset values.
// No dependencies; every other file in rtl/ except art1_mem refers to it by scoped names.
`default_nettype none

package art1_pkg;

   localparam int FEATURE_W  = 64;
   localparam int CATEGORY_W = 6;
   localparam int STATUS_W   = 2;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 17;
   localparam int VIG_W      = 17;
   localparam int CHOICE_W   = 16;
   localparam int FCOUNT_W   = 7;
   localparam int RHS_W      = VIG_W + FCOUNT_W;
   // Effective choice denominator, always positive, below 2^17.
   localparam int DEN_W      = 17;
   // Raw denominator, signed, wide enough for the Q8.8 parameter plus the size term.
   localparam int DEN_RAW_W  = 19;

   localparam logic FUNC_LEARN    = 1'b0;
   localparam logic FUNC_CLASSIFY = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] CSR_VIGILANCE = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_CHOICE    = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_FEATURES  = 2'd2;

   localparam logic [VIG_W-1:0]    VIGILANCE_RESET = 17'd32768;
   localparam logic [CHOICE_W-1:0] CHOICE_RESET    = 16'd512;
   localparam logic [FCOUNT_W-1:0] FEATURES_RESET  = 7'd64;

   typedef struct packed {
      logic                 func;
      logic [FEATURE_W-1:0] feature_bits;
   } req_type;

   typedef struct packed {
      logic [CATEGORY_W-1:0] category;
      logic                  created;
      logic [STATUS_W-1:0]   status;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/art1_mem.sv =====
// Template store: one write port and one read port with registered read data.
// Each word holds a template's size count above its feature bits.
// No package dependencies.
`default_nettype none

module art1_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6,
   parameter int DW    = 71
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [DW-1:0] rd_data_ff
);

   logic [DW-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/art1_score.sv =====
// Scoring stage: overlap count, vigilance test and choice denominator for one template.
// Results are registered for the best-category compare that follows.
// Depends on art1_pkg.
`default_nettype none

module art1_score #(
   parameter int FW = 64,
   parameter int SW = 7
) (
   input  wire logic                                 clock,
   input  wire logic                                 en,
   input  wire logic                                 classify,
   input  wire logic [FW-1:0]                        x,
   input  wire logic [FW-1:0]                        tmpl_bits,
   input  wire logic [SW-1:0]                        tmpl_size,
   input  wire logic [art1_pkg::CHOICE_W-1:0]        lq,
   input  wire logic [art1_pkg::RHS_W-1:0]           rhs,
   output logic      [SW-1:0]                        a_ff,
   output logic      [SW-1:0]                        a_eff_ff,
   output logic      [art1_pkg::DEN_W-1:0]           den_ff,
   output logic                                      pass_ff,
   output logic      [FW-1:0]                        meet_ff
);

   logic [FW-1:0] meet;
   logic [63:0]   v;
   logic [1:0]    s1 [32];
   logic [2:0]    s2 [16];
   logic [3:0]    s3 [8];
   logic [4:0]    s4 [4];
   logic [5:0]    s5 [2];
   logic [6:0]    s6;
   logic [SW-1:0] a;
   logic signed [art1_pkg::DEN_RAW_W-1:0] den_raw;
   logic          den_pos;
   logic [art1_pkg::RHS_W-1:0] lhs;

   assign meet = x & tmpl_bits;
   assign v    = 64'(meet);

   // Balanced adder tree for the population count.
   always_comb begin
      for (int i = 0; i < 32; i++) s1[i] = 2'(v[2*i]) + 2'(v[2*i+1]);
      for (int i = 0; i < 16; i++) s2[i] = 3'(s1[2*i]) + 3'(s1[2*i+1]);
      for (int i = 0; i < 8; i++)  s3[i] = 4'(s2[2*i]) + 4'(s2[2*i+1]);
      for (int i = 0; i < 4; i++)  s4[i] = 5'(s3[2*i]) + 5'(s3[2*i+1]);
      for (int i = 0; i < 2; i++)  s5[i] = 6'(s4[2*i]) + 6'(s4[2*i+1]);
      s6 = 7'(s5[0]) + 7'(s5[1]);
   end

   assign a = SW'(s6);

   assign den_raw = $signed(art1_pkg::DEN_RAW_W'(lq))
                  + $signed(art1_pkg::DEN_RAW_W'({tmpl_size, 8'h00}))
                  - $signed(art1_pkg::DEN_RAW_W'(256));
   assign den_pos = !den_raw[art1_pkg::DEN_RAW_W-1] && (den_raw != '0);
   assign lhs     = art1_pkg::RHS_W'({a, 16'h0000});

   // A zero choice parameter or a non-positive denominator both give a zero choice, carried
   // as a zero overlap; a non-positive denominator is also replaced by a unit denominator.
   always_ff @(posedge clock) begin
      if (en) begin
         a_ff     <= a;
         a_eff_ff <= (den_pos && (lq != '0)) ? a : '0;
         den_ff   <= den_pos ? den_raw[art1_pkg::DEN_W-1:0] : art1_pkg::DEN_W'(1);
         pass_ff  <= classify || (lhs >= rhs);
         meet_ff  <= meet;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/art1_binary_clustering.sv =====
// ART1 binary clustering block: each request is scored against every stored template,
// one template per cycle through a single read port and one shared scoring datapath.
// A transaction is accepted, then the N stored templates are read, where N is the number
// of categories stored so far (at most MAX_CATEGORIES); the read and scoring stages
// drain, the sequencer sees the pipeline empty, and the finishing step loads the response
// register and, when learning into a matched or new category, writes back the template.
// With no categories stored the scan is empty. The request side is not ready until that
// response is loaded; a pending response only delays the finishing step.
// The category count tracks which templates exist, so no memory clearing follows reset.
`default_nettype none

module art1_binary_clustering #(
   parameter int MAX_CATEGORIES = 64,
   parameter int MAX_FEATURES   = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire art1_pkg::req_type                   req_payload,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output art1_pkg::rsp_type                        rsp_payload,
   input  wire logic                                csr_we,
   input  wire logic [art1_pkg::CSR_ADDR_W-1:0]     csr_index,
   input  wire logic [art1_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int CW = $clog2(MAX_CATEGORIES);
   localparam int NW = $clog2(MAX_CATEGORIES + 1);
   localparam int FW = MAX_FEATURES;
   localparam int SW = $clog2(MAX_FEATURES + 1);
   localparam int MW = SW + FW;
   localparam int PW = SW + art1_pkg::DEN_W;
   localparam logic [art1_pkg::FCOUNT_W-1:0] MAXF = art1_pkg::FCOUNT_W'(MAX_FEATURES);
   localparam logic [NW-1:0] MAXC = NW'(MAX_CATEGORIES);

   art1_pkg::state_type state_ff, state_in;

   logic [art1_pkg::VIG_W-1:0]    vig_ff;
   logic [art1_pkg::CHOICE_W-1:0] lq_ff;
   logic [art1_pkg::FCOUNT_W-1:0] fc_ff;

   logic [art1_pkg::FCOUNT_W-1:0] f_eff;
   logic [FW-1:0]                 mask;
   logic [FW-1:0]                 x_in;
   logic [art1_pkg::RHS_W-1:0]    rhs_in;

   logic [FW-1:0]                 x_ff;
   logic [art1_pkg::FCOUNT_W-1:0] f_ff;
   logic [art1_pkg::RHS_W-1:0]    rhs_ff;
   logic                          classify_ff;

   logic [NW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0] issue_ff;
   logic          v1_ff, v2_ff;
   logic [CW-1:0] idx1_ff, idx2_ff;

   logic          accept, rd_en, finish;

   logic [MW-1:0] rd_data_ff;
   logic          wr_en;
   logic [CW-1:0] wr_addr;
   logic [MW-1:0] wr_data;

   logic [SW-1:0]                sc_a, sc_aeff;
   logic [art1_pkg::DEN_W-1:0]   sc_den;
   logic                         sc_pass;
   logic [FW-1:0]                sc_meet;

   logic                         found_ff;
   logic [CW-1:0]                best_idx_ff;
   logic [SW-1:0]                best_aeff_ff, best_size_ff;
   logic [art1_pkg::DEN_W-1:0]   best_den_ff;
   logic [FW-1:0]                best_meet_ff;
   logic [PW-1:0]                prod_new, prod_best;
   logic                         take;

   logic                         rsp_valid_ff, rsp_valid_in;
   art1_pkg::rsp_type            rsp_payload_ff, rsp_payload_in;
   logic [CW-1:0]                res_idx;

   // Effective feature count and the mask of features in use.
   assign f_eff = (fc_ff > MAXF) ? MAXF : fc_ff;

   always_comb begin
      for (int j = 0; j < FW; j++) begin
         mask[j] = art1_pkg::FCOUNT_W'(j) < f_eff;
      end
   end

   assign x_in   = req_payload.feature_bits[FW-1:0] & mask;
   assign rhs_in = art1_pkg::RHS_W'(vig_ff) * art1_pkg::RHS_W'(f_eff);

   // Sequencer: next state and strobes.
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      accept    = 1'b0;
      rd_en     = 1'b0;
      finish    = 1'b0;
      case (state_ff)
         art1_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               accept   = 1'b1;
               state_in = art1_pkg::ST_SCAN;
            end
         end
         art1_pkg::ST_SCAN: begin
            rd_en = issue_ff < cnt_ff;
            if (!rd_en && !v1_ff && !v2_ff) begin
               state_in = art1_pkg::ST_FINISH;
            end
         end
         art1_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               finish   = 1'b1;
               state_in = art1_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = art1_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= art1_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   art1_mem #(
      .DEPTH (MAX_CATEGORIES),
      .AW    (CW),
      .DW    (MW)
   ) u_mem (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (issue_ff[CW-1:0]),
      .rd_data_ff (rd_data_ff)
   );

   art1_score #(
      .FW (FW),
      .SW (SW)
   ) u_score (
      .clock     (clock),
      .en        (v1_ff),
      .classify  (classify_ff),
      .x         (x_ff),
      .tmpl_bits (rd_data_ff[FW-1:0]),
      .tmpl_size (rd_data_ff[MW-1:FW]),
      .lq        (lq_ff),
      .rhs       (rhs_ff),
      .a_ff      (sc_a),
      .a_eff_ff  (sc_aeff),
      .den_ff    (sc_den),
      .pass_ff   (sc_pass),
      .meet_ff   (sc_meet)
   );

   // Exact choice compare by cross-multiplication; the common factor L drops out.
   assign prod_new  = PW'(sc_aeff) * PW'(best_den_ff);
   assign prod_best = PW'(best_aeff_ff) * PW'(sc_den);
   assign take      = v2_ff && sc_pass && (!found_ff || (prod_new > prod_best));

   // Write-back and response for the finishing cycle.
   always_comb begin
      wr_en          = 1'b0;
      wr_addr        = cnt_ff[CW-1:0];
      wr_data        = {SW'(f_ff), x_ff};
      cnt_in         = cnt_ff;
      res_idx        = best_idx_ff;
      rsp_payload_in = '0;
      rsp_payload_in.status = art1_pkg::STATUS_OK;
      if (classify_ff == art1_pkg::FUNC_CLASSIFY) begin
         if (!found_ff) begin
            res_idx               = '0;
            rsp_payload_in.status = art1_pkg::STATUS_EMPTY;
         end
      end else if (found_ff) begin
         wr_en   = finish;
         wr_addr = best_idx_ff;
         wr_data = {best_size_ff, best_meet_ff};
      end else if (cnt_ff < MAXC) begin
         wr_en                  = finish;
         res_idx                = cnt_ff[CW-1:0];
         cnt_in                 = cnt_ff + NW'(1);
         rsp_payload_in.created = 1'b1;
      end else begin
         res_idx               = '0;
         rsp_payload_in.status = art1_pkg::STATUS_FULL;
      end
      rsp_payload_in.category = art1_pkg::CATEGORY_W'(res_idx);

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vig_ff       <= art1_pkg::VIGILANCE_RESET;
         lq_ff        <= art1_pkg::CHOICE_RESET;
         fc_ff        <= art1_pkg::FEATURES_RESET;
         cnt_ff       <= '0;
         issue_ff     <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               art1_pkg::CSR_VIGILANCE: vig_ff <= csr_wdata[art1_pkg::VIG_W-1:0];
               art1_pkg::CSR_CHOICE:    lq_ff  <= csr_wdata[art1_pkg::CHOICE_W-1:0];
               art1_pkg::CSR_FEATURES:  fc_ff  <= csr_wdata[art1_pkg::FCOUNT_W-1:0];
               default: ;
            endcase
         end
         if (finish) begin
            cnt_ff <= cnt_in;
         end
         if (accept) begin
            issue_ff <= '0;
         end else if (rd_en) begin
            issue_ff <= issue_ff + NW'(1);
         end
         v1_ff <= rd_en;
         v2_ff <= v1_ff;
         if (accept) begin
            found_ff <= 1'b0;
         end else if (take) begin
            found_ff <= 1'b1;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx1_ff <= issue_ff[CW-1:0];
      idx2_ff <= idx1_ff;
      if (accept) begin
         x_ff        <= x_in;
         f_ff        <= f_eff;
         rhs_ff      <= rhs_in;
         classify_ff <= req_payload.func;
      end
      if (take) begin
         best_idx_ff  <= idx2_ff;
         best_aeff_ff <= sc_aeff;
         best_den_ff  <= sc_den;
         best_size_ff <= sc_a;
         best_meet_ff <= sc_meet;
      end
      if (finish) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

// ===== rtl/art1_checker.sv =====
// Port-level checks for the ART1 binary clustering block, bound to the top level.
// Depends on art1_pkg and art1_binary_clustering.
`default_nettype none

module art1_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_ready,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire art1_pkg::rsp_type               rsp_payload
);

   // A stalled response keeps its valid and its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   // The block works on one transaction at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.status == art1_pkg::STATUS_OK) ||
                    (rsp_payload.status == art1_pkg::STATUS_FULL) ||
                    (rsp_payload.status == art1_pkg::STATUS_EMPTY))
      else $error("undefined status code");

   a_created_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.created |-> rsp_payload.status == art1_pkg::STATUS_OK)
      else $error("new category reported with an error status");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status != art1_pkg::STATUS_OK) |->
         (rsp_payload.category == '0) && !rsp_payload.created)
      else $error("error response carries a category");

endmodule

bind art1_binary_clustering art1_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
